// ===== sv/adaptive_notch_filter_top_macros.svh =====
// Assertion macros for the adaptive notch filter top level.
`ifndef ADAPTIVE_NOTCH_FILTER_TOP_MACROS_SVH
`define ADAPTIVE_NOTCH_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ANF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ANF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/anf_pkg.sv =====
// Shared types, constants and microcode table for the adaptive notch filter.
package anf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OPA_W     = 24;
    localparam int OPB_W     = 17;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int ACC_W     = 26;
    localparam int ERR_W     = 24;
    localparam int UCODE_DEPTH = 16;
    localparam int PC_W      = $clog2(UCODE_DEPTH);
    localparam int COEF_LIMIT = 16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORGET_FACTOR,
        CFG_FORGET_COMPLEMENT,
        CFG_STEP_SIZE,
        CFG_RADIUS_FINAL,
        CFG_RADIUS_START,
        CFG_COEF_START
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_RETURN
    } seq_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_FF,
        A_FC,
        A_SS,
        A_R,
        A_T4,
        A_H1,
        A_H0,
        A_E
    } asel_t;

    typedef enum logic [2:0] {
        B_NONE,
        B_R,
        B_RF,
        B_H0,
        B_A,
        B_Q,
        B_NA,
        B_G
    } bsel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_T,
        OP_RADIUS,
        OP_LOAD_G,
        OP_LOAD_Q,
        OP_SUB_T,
        OP_LOAD_U,
        OP_HIST,
        OP_ERR,
        OP_COEF,
        OP_PUBLISH
    } op_t;

    typedef enum logic [1:0] {
        RND_9,
        RND_11,
        RND_15
    } rnd_t;

    typedef struct packed {
        seq_t  seq;
        asel_t asel;
        bsel_t bsel;
        op_t   op;
        rnd_t  rnd;
    } uword_t;

    typedef struct packed {
        logic   exec;
        uword_t word;
    } ctrl_t;

    function automatic uword_t mk(seq_t s, asel_t a, bsel_t b, op_t o, rnd_t r);
        uword_t w;
        w.seq  = s;
        w.asel = a;
        w.bsel = b;
        w.op   = o;
        w.rnd  = r;
        return w;
    endfunction

    // Each word multiplies its operands and applies op to the previous product.
    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:    w = mk(SEQ_WAIT_IN, A_NONE, B_NONE, OP_CAPTURE, RND_9);
            4'd1:    w = mk(SEQ_NEXT,    A_FF,   B_R,    OP_NONE,    RND_9);
            4'd2:    w = mk(SEQ_NEXT,    A_FC,   B_RF,   OP_LOAD_T,  RND_15);
            4'd3:    w = mk(SEQ_NEXT,    A_SS,   B_H0,   OP_RADIUS,  RND_15);
            4'd4:    w = mk(SEQ_NEXT,    A_R,    B_H0,   OP_LOAD_G,  RND_11);
            4'd5:    w = mk(SEQ_NEXT,    A_R,    B_R,    OP_LOAD_T,  RND_11);
            4'd6:    w = mk(SEQ_NEXT,    A_T4,   B_A,    OP_LOAD_Q,  RND_15);
            4'd7:    w = mk(SEQ_NEXT,    A_H1,   B_Q,    OP_LOAD_T,  RND_11);
            4'd8:    w = mk(SEQ_NEXT,    A_H0,   B_NA,   OP_SUB_T,   RND_11);
            4'd9:    w = mk(SEQ_NEXT,    A_NONE, B_NONE, OP_LOAD_U,  RND_9);
            4'd10:   w = mk(SEQ_NEXT,    A_NONE, B_NONE, OP_HIST,    RND_9);
            4'd11:   w = mk(SEQ_NEXT,    A_NONE, B_NONE, OP_ERR,     RND_9);
            4'd12:   w = mk(SEQ_NEXT,    A_E,    B_G,    OP_NONE,    RND_9);
            4'd13:   w = mk(SEQ_NEXT,    A_NONE, B_NONE, OP_LOAD_T,  RND_15);
            4'd14:   w = mk(SEQ_NEXT,    A_NONE, B_NONE, OP_COEF,    RND_9);
            4'd15:   w = mk(SEQ_RETURN,  A_NONE, B_NONE, OP_PUBLISH, RND_9);
            default: w = mk(SEQ_WAIT_IN, A_NONE, B_NONE, OP_CAPTURE, RND_9);
        endcase
        return w;
    endfunction

endpackage

// ===== sv/anf_sequencer.sv =====
// Microcode sequencer: step counter, control store and wait conditions.
module anf_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_free,
    output logic          in_ready,
    output anf_pkg::ctrl_t ctrl
);
    import anf_pkg::*;

    localparam logic [PC_W-1:0] PC_START = '0;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          word;
    logic            exec;

    assign word = ucode(pc_reg);

    always_comb
    begin
        exec    = 1'b1;
        pc_next = PC_W'(pc_reg + 1'b1);
        case (word.seq)
            SEQ_NEXT:
            begin
                exec    = 1'b1;
                pc_next = PC_W'(pc_reg + 1'b1);
            end
            SEQ_WAIT_IN:
            begin
                exec    = in_valid;
                pc_next = in_valid ? PC_W'(pc_reg + 1'b1) : pc_reg;
            end
            SEQ_RETURN:
            begin
                exec    = out_free;
                pc_next = out_free ? PC_START : pc_reg;
            end
            default:
            begin
                exec    = 1'b0;
                pc_next = PC_START;
            end
        endcase
    end

    assign in_ready  = (word.seq == SEQ_WAIT_IN);
    assign ctrl.exec = exec;
    assign ctrl.word = word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_START;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/anf_datapath.sv =====
// Datapath: configuration, filter state, shared multiplier and rounding unit.
module anf_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  anf_pkg::ctrl_t                        ctrl,
    input  logic signed [anf_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                  cfg_we,
    input  logic [anf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [anf_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic signed [anf_pkg::SAMPLE_W-1:0]   err
);
    import anf_pkg::*;

    logic [CFG_W-1:0]           ff_reg, ff_next;
    logic [CFG_W-1:0]           fc_reg, fc_next;
    logic [CFG_W-1:0]           ss_reg, ss_next;
    logic [CFG_W-1:0]           rf_reg, rf_next;
    logic signed [SAMPLE_W-1:0] radius_reg, radius_next;
    logic signed [SAMPLE_W-1:0] coef_reg, coef_next;
    logic signed [SAMPLE_W-1:0] hist0_reg, hist0_next;
    logic signed [SAMPLE_W-1:0] hist1_reg, hist1_next;

    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [ACC_W-1:0]    t_reg, t_next;
    logic signed [ERR_W-1:0]    u_reg, u_next;
    logic signed [ERR_W-1:0]    e_reg, e_next;
    logic signed [SAMPLE_W-1:0] g_reg, g_next;
    logic signed [SAMPLE_W-1:0] q_reg, q_next;
    logic signed [PROD_W-1:0]   prod_reg;

    logic signed [OPA_W-1:0]    opa;
    logic signed [OPB_W-1:0]    opb;
    logic signed [PROD_W:0]     rval;
    logic signed [ACC_W:0]      rad_sum;
    logic signed [ACC_W:0]      hist_sum;
    logic signed [ACC_W:0]      inc_wide;
    logic signed [SAMPLE_W-1:0] inc;
    logic signed [SAMPLE_W:0]   coef_sum;
    logic signed [SAMPLE_W-1:0] coef_sat;
    logic                       do_op;

    assign do_op = ctrl.exec;
    assign err   = e_reg[SAMPLE_W-1:0];

    always_comb
    begin
        case (ctrl.word.asel)
            A_NONE:  opa = '0;
            A_FF:    opa = OPA_W'({1'b0, ff_reg});
            A_FC:    opa = OPA_W'({1'b0, fc_reg});
            A_SS:    opa = OPA_W'({1'b0, ss_reg});
            A_R:     opa = OPA_W'(radius_reg);
            A_T4:    opa = OPA_W'(t_reg >>> 2);
            A_H1:    opa = OPA_W'(hist1_reg);
            A_H0:    opa = OPA_W'(hist0_reg);
            A_E:     opa = OPA_W'(e_reg);
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.word.bsel)
            B_NONE:  opb = '0;
            B_R:     opb = OPB_W'(radius_reg);
            B_RF:    opb = OPB_W'({1'b0, rf_reg});
            B_H0:    opb = OPB_W'(hist0_reg);
            B_A:     opb = OPB_W'(coef_reg);
            B_Q:     opb = OPB_W'(q_reg);
            B_NA:    opb = -OPB_W'(coef_reg);
            B_G:     opb = OPB_W'(g_reg);
            default: opb = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.word.rnd)
            RND_9:   rval = ((PROD_W+1)'(prod_reg) + (PROD_W+1)'(256)) >>> 9;
            RND_11:  rval = ((PROD_W+1)'(prod_reg) + (PROD_W+1)'(1024)) >>> 11;
            RND_15:  rval = ((PROD_W+1)'(prod_reg) + (PROD_W+1)'(16384)) >>> 15;
            default: rval = '0;
        endcase
    end

    always_comb
    begin
        rad_sum  = (ACC_W+1)'(t_reg) + (ACC_W+1)'(rval);
        hist_sum = (ACC_W+1)'(y_reg) + (ACC_W+1)'(t_reg);
        inc_wide = ((ACC_W+1)'(t_reg) + (ACC_W+1)'(2)) >>> 2;
        inc      = inc_wide[SAMPLE_W-1:0];
        coef_sum = (SAMPLE_W+1)'(coef_reg) + (SAMPLE_W+1)'(inc);
        if (coef_sum < -(SAMPLE_W+1)'(COEF_LIMIT))
        begin
            coef_sat = -SAMPLE_W'(COEF_LIMIT);
        end
        else if (coef_sum > (SAMPLE_W+1)'(COEF_LIMIT))
        begin
            coef_sat = SAMPLE_W'(COEF_LIMIT);
        end
        else
        begin
            coef_sat = coef_sum[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        ff_next     = ff_reg;
        fc_next     = fc_reg;
        ss_next     = ss_reg;
        rf_next     = rf_reg;
        radius_next = radius_reg;
        coef_next   = coef_reg;
        hist0_next  = hist0_reg;
        hist1_next  = hist1_reg;
        y_next      = y_reg;
        t_next      = t_reg;
        u_next      = u_reg;
        e_next      = e_reg;
        g_next      = g_reg;
        q_next      = q_reg;

        if (do_op)
        begin
            case (ctrl.word.op)
                OP_NONE:    ;
                OP_CAPTURE: y_next = sample_in;
                OP_LOAD_T:  t_next = ACC_W'(rval);
                OP_RADIUS:  radius_next = rad_sum[SAMPLE_W-1:0];
                OP_LOAD_G:  g_next = rval[SAMPLE_W-1:0];
                OP_LOAD_Q:  q_next = rval[SAMPLE_W-1:0];
                OP_SUB_T:   t_next = t_reg - ACC_W'(rval);
                OP_LOAD_U:  u_next = ERR_W'(rval) + (ERR_W'(hist1_reg) <<< 4);
                OP_HIST:
                begin
                    hist1_next = hist0_reg;
                    hist0_next = hist_sum[SAMPLE_W+3:4];
                end
                OP_ERR:     e_next = (ERR_W'(hist0_reg) <<< 4) + u_reg;
                OP_COEF:    coef_next = coef_sat;
                OP_PUBLISH: ;
                default:    ;
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORGET_FACTOR:     ff_next = cfg_data[CFG_W-1:0];
                CFG_FORGET_COMPLEMENT: fc_next = cfg_data[CFG_W-1:0];
                CFG_STEP_SIZE:         ss_next = cfg_data[CFG_W-1:0];
                CFG_RADIUS_FINAL:      rf_next = cfg_data[CFG_W-1:0];
                CFG_RADIUS_START:      radius_next = {1'b0, cfg_data[CFG_W-1:0]};
                CFG_COEF_START:        coef_next = cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg     <= '0;
            fc_reg     <= '0;
            ss_reg     <= '0;
            rf_reg     <= '0;
            radius_reg <= '0;
            coef_reg   <= '0;
            hist0_reg  <= '0;
            hist1_reg  <= '0;
        end
        else
        begin
            ff_reg     <= ff_next;
            fc_reg     <= fc_next;
            ss_reg     <= ss_next;
            rf_reg     <= rf_next;
            radius_reg <= radius_next;
            coef_reg   <= coef_next;
            hist0_reg  <= hist0_next;
            hist1_reg  <= hist1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        e_reg    <= e_next;
        g_reg    <= g_next;
        q_reg    <= q_next;
        prod_reg <= opa * opb;
    end

endmodule

// ===== sv/adaptive_notch_filter_top.sv =====
// Top level of the adaptive notch filter: sequencer, datapath and result register.
//
// Input channel: sample_in with in_valid/in_ready; one Q15 sample per transaction.
// Output channel: error_out with out_valid/out_ready; one Q15 error sample per
// input transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle, no wait;
// write only while no sample is in flight. Writing the start radius or start
// coefficient also loads the running radius or coefficient.
// Schedule: a 16-word microprogram drives one shared 24x17 multiplier with a
// registered product. A sample accepted at the first step shows on error_out once
// the program reaches its publish step; no new sample is taken before it returns.
// The program length follows from its work: nine products pass one at a time through
// the multiplier, with capture, accumulate, write-back and publish steps around them.
// Stall: if the result register still holds an untaken result, the program
// holds at its last step and in_ready stays low until out_ready frees the slot.
// Reset: clears configuration, radius, coefficient, sample history and the
// output valid; the block then waits for its first sample.
`include "adaptive_notch_filter_top_macros.svh"

module adaptive_notch_filter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [anf_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [anf_pkg::SAMPLE_W-1:0]   error_out,
    input  logic                                  cfg_we,
    input  logic [anf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [anf_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import anf_pkg::*;

    ctrl_t                      ctrl;
    logic                       out_free;
    logic                       publish;
    logic signed [SAMPLE_W-1:0] dp_err;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] error_out_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign publish  = ctrl.exec && (ctrl.word.op == OP_PUBLISH);

    anf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    anf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample_in (sample_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .err       (dp_err)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            error_out_reg <= dp_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign error_out = error_out_reg;

    `ANF_ASSERT_IMPL(a_no_overwrite, publish, (!out_valid_reg || out_ready), "pending result overwritten")
    `ANF_ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "second sample taken while busy")
    `ANF_ASSERT_IMPL(a_valid_from_publish, $rose(out_valid_reg), $past(publish), "result valid without publish")

endmodule
